[rtl/arp_pkg.sv]
// ----------------------------------------------------------------------------
// ARP cache package
// Shared constants, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package arp_pkg;
   localparam int ENTRIES_DEFAULT = 16;
   localparam int MAX_RESULTS = 16;
   localparam int MAX_RESULTS_W = 5;

   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_ANSWER  = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;
   localparam logic [1:0] KIND_REQUEST = 2'd3;

   localparam logic [2:0] CSR_MY_IP        = 3'd0;
   localparam logic [2:0] CSR_ENTRY_LIFE   = 3'd1;
   localparam logic [2:0] CSR_REQUEST_LIFE = 3'd2;
   localparam logic [2:0] CSR_REFRESH_WIN  = 3'd3;
   localparam logic [2:0] CSR_IN_USE_THR   = 3'd4;

   localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;
   localparam logic [7:0]  USE_FULL      = 8'hFF;
   localparam logic [7:0]  LIFE_MAX      = 8'd255;
   localparam logic [15:0] HTYPE_ETH     = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
   localparam logic [15:0] AOP_REQUEST   = 16'h0001;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request fields, clear scan state
      logic scan;      // examine slot at scan index
      logic learn;     // write learned entry to chosen slot
      logic claim;     // write pending entry to chosen slot
      logic hit_use;   // set use timer of hit slot
      logic tick;      // age slot at scan index
      logic next;      // advance scan index
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       scan_last;   // scan index is at last slot
      logic       pkt_ok;      // packet passes checks
      logic       is_req;      // packet is an ARP request
      logic       match;       // some slot matched during scan
      logic       match_done;  // match done at or before current index
      logic       emit_tick;   // current slot emits on tick
   } sts_type;
endpackage

[rtl/arp_datapath.sv]
// ----------------------------------------------------------------------------
// ARP cache datapath
// Slot table, request capture, slot scan with match and victim search.
// ----------------------------------------------------------------------------
module arp_datapath import arp_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT,
   localparam int IW = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic [1:0]    req_opcode,
   input  logic [31:0]   req_peer_ip,
   input  logic [47:0]   req_sender_mac,
   input  logic [31:0]   req_target_ip,
   input  logic [15:0]   req_hw_type,
   input  logic [15:0]   req_proto_type,
   input  logic [15:0]   req_arp_opcode,
   input  logic          req_too_short,
   input  logic [31:0]   my_ip,
   input  logic [7:0]    entry_lifetime,
   input  logic [7:0]    request_lifetime,
   input  logic [7:0]    refresh_window,
   input  logic [7:0]    in_use_threshold,
   output logic [47:0]   ans_mac,
   output logic [31:0]   peer_ip,
   output logic [47:0]   peer_mac,
   output logic [31:0]   scan_ip
);
   logic [31:0] ip_ff    [ENTRIES];
   logic [47:0] mac_ff   [ENTRIES];
   logic        cmp_ff   [ENTRIES];
   logic [7:0]  exp_ff   [ENTRIES];
   logic [7:0]  use_ff   [ENTRIES];

   logic [31:0] peer_ff;
   logic [47:0] smac_ff;
   logic        ok_ff, isreq_ff;
   logic [1:0]  op_ff;
   logic [IW-1:0] idx_ff;
   logic        match_ff, found_ff, zero_ff;
   logic [IW-1:0] hit_ff, vic_ff;
   logic [7:0]  low_ff;
   logic [47:0] ans_ff;
   logic [7:0]  e_dec, u_dec;
   logic        ipeq, live_hit, cand;
   logic [IW-1:0] tgt;

   assign ipeq = ip_ff[idx_ff] == peer_ff;
   // packet: first IP match at any expiry; lookup: needs live entry
   assign live_hit = ipeq && ((op_ff == OP_PACKET) || (exp_ff[idx_ff] != 8'd0));
   assign cand = !zero_ff && ((exp_ff[idx_ff] == 8'd0) || (exp_ff[idx_ff] < low_ff));
   assign e_dec = (exp_ff[idx_ff] != 8'd0) ? exp_ff[idx_ff] - 8'd1 : 8'd0;
   assign u_dec = (use_ff[idx_ff] != 8'd0) ? use_ff[idx_ff] - 8'd1 : 8'd0;
   assign tgt = match_ff ? hit_ff : vic_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            ip_ff[i] <= '0; mac_ff[i] <= '0; cmp_ff[i] <= 1'b0;
            exp_ff[i] <= '0; use_ff[i] <= '0;
         end
         idx_ff <= '0; match_ff <= 1'b0; zero_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            peer_ff  <= req_peer_ip;
            smac_ff  <= req_sender_mac;
            op_ff    <= req_opcode;
            ok_ff    <= !req_too_short && req_hw_type == HTYPE_ETH &&
                        req_proto_type == PTYPE_IPV4 && req_target_ip == my_ip;
            isreq_ff <= req_arp_opcode == AOP_REQUEST;
            idx_ff   <= '0;
            match_ff <= 1'b0;
            zero_ff  <= 1'b0;
            low_ff   <= LIFE_MAX;
            vic_ff   <= '0;
            ans_ff   <= BROADCAST_MAC;
         end
         if (cmd.scan) begin
            if (!match_ff && live_hit) begin
               match_ff <= 1'b1;
               hit_ff   <= idx_ff;
               if (cmp_ff[idx_ff]) ans_ff <= mac_ff[idx_ff];
            end
            if (cand) begin
               vic_ff <= idx_ff;
               low_ff <= exp_ff[idx_ff];
               if (exp_ff[idx_ff] == 8'd0) zero_ff <= 1'b1;
            end
         end
         if (cmd.tick) begin
            exp_ff[idx_ff] <= e_dec;
            use_ff[idx_ff] <= u_dec;
         end
         if (cmd.learn) begin
            ip_ff[tgt]  <= peer_ff;
            cmp_ff[tgt] <= 1'b1;
            mac_ff[tgt] <= smac_ff;
            exp_ff[tgt] <= entry_lifetime;
         end
         if (cmd.claim) begin
            ip_ff[vic_ff]  <= peer_ff;
            cmp_ff[vic_ff] <= 1'b0;
            exp_ff[vic_ff] <= request_lifetime;
         end
         if (cmd.hit_use && cmp_ff[hit_ff]) use_ff[hit_ff] <= USE_FULL;
         if (cmd.next) idx_ff <= idx_ff + 1'b1;
      end
   end

   assign sts.scan_last  = idx_ff == IW'(ENTRIES - 1);
   assign sts.pkt_ok     = ok_ff;
   assign sts.is_req     = isreq_ff;
   assign sts.match      = match_ff;
   assign sts.match_done = match_ff || live_hit;
   assign sts.emit_tick  = (e_dec != 8'd0 && !cmp_ff[idx_ff]) ||
                           (cmp_ff[idx_ff] && e_dec < refresh_window &&
                            u_dec > in_use_threshold);
   assign ans_mac  = ans_ff;
   assign peer_ip  = peer_ff;
   assign peer_mac = smac_ff;
   assign scan_ip  = ip_ff[idx_ff];
endmodule

[rtl/arp_ctrl.sv]
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences scan, update and result emission for each request.
// ----------------------------------------------------------------------------
module arp_ctrl import arp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  opcode,
   output logic        busy,
   output cmd_type     cmd,
   input  sts_type     sts,
   input  logic [47:0] ans_mac,
   input  logic [31:0] peer_ip,
   input  logic [47:0] peer_mac,
   input  logic [31:0] scan_ip,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [47:0] rsp_dest_mac,
   output logic [31:0] rsp_result_ip,
   output logic        rsp_last
);
   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_UPD = 3'd2,
                          S_ANS = 3'd3, S_TICK = 3'd4, S_NONE = 3'd5;
   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff;
   logic [MAX_RESULTS_W-1:0] cnt_ff, cnt_in;
   // one pending tick result is held back so its last flag is known
   logic        pend_ff, pend_in;
   logic [31:0] pip_ff, pip_in;
   logic        v_in, l_in;
   logic [1:0]  k_in;
   logic [47:0] m_in;
   logic [31:0] i_in;
   logic        emit_now;

   assign busy = state_ff != S_IDLE;
   assign emit_now = sts.emit_tick && cnt_ff != MAX_RESULTS_W'(MAX_RESULTS);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; pend_in = pend_ff; pip_in = pip_ff;
      cmd = '0; v_in = 1'b0; k_in = KIND_NONE; m_in = '0; i_in = '0; l_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1; cnt_in = '0; pend_in = 1'b0;
            state_in = (opcode == OP_TICK) ? S_TICK :
                       (opcode == OP_PACKET || opcode == OP_LOOKUP) ? S_SCAN : S_NONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (op_ff == OP_PACKET && !sts.pkt_ok) state_in = S_NONE;
            else if (sts.scan_last || (op_ff == OP_LOOKUP && sts.match_done))
               state_in = S_UPD;
            else cmd.next = 1'b1;
         end
         S_UPD: begin
            if (op_ff == OP_PACKET) begin
               cmd.learn = 1'b1;
               if (sts.is_req) begin
                  v_in = 1'b1; k_in = KIND_REPLY; m_in = peer_mac; i_in = peer_ip;
                  l_in = 1'b1; state_in = S_IDLE;
               end else state_in = S_NONE;
            end else if (sts.match) begin
               cmd.hit_use = 1'b1; state_in = S_ANS;
            end else begin
               cmd.claim = 1'b1; v_in = 1'b1; k_in = KIND_REQUEST;
               m_in = BROADCAST_MAC; i_in = peer_ip; state_in = S_ANS;
            end
         end
         S_ANS: begin
            v_in = 1'b1; k_in = KIND_ANSWER; m_in = ans_mac; i_in = peer_ip;
            l_in = 1'b1; state_in = S_IDLE;
         end
         S_TICK: begin
            cmd.tick = 1'b1; cmd.next = !sts.scan_last;
            if (emit_now) begin
               if (pend_ff) begin
                  v_in = 1'b1; k_in = KIND_REQUEST; m_in = BROADCAST_MAC; i_in = pip_ff;
               end
               pend_in = 1'b1; pip_in = scan_ip; cnt_in = cnt_ff + 1'b1;
            end
            if (sts.scan_last) state_in = S_NONE;
         end
         S_NONE: begin
            v_in = 1'b1; l_in = 1'b1; state_in = S_IDLE;
            if (pend_ff) begin
               k_in = KIND_REQUEST; m_in = BROADCAST_MAC; i_in = pip_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid <= 1'b0; cnt_ff <= '0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid <= v_in; cnt_ff <= cnt_in; pend_ff <= pend_in;
      end
      pip_ff <= pip_in;
      if (state_ff == S_IDLE && start) op_ff <= opcode;
      rsp_kind <= k_in; rsp_dest_mac <= m_in; rsp_result_ip <= i_in; rsp_last <= l_in;
   end
endmodule

[rtl/arp_cache_engine_top.sv]
// ----------------------------------------------------------------------------
// ARP cache engine
// Slot-scanning ARP cache: packet learning, lookups and aging on each tick request.
// ----------------------------------------------------------------------------
// Usage:
//  - Pulse start with req_* fields while busy is low; the request is taken
//    at that edge. busy stays high until the last result has been issued.
//  - Results appear on rsp_* for one cycle each, marked by rsp_valid;
//    rsp_last flags the final result of a request. The receiver cannot stall.
//  - Packet, lookup and tick requests scan the slot table one slot per cycle
//    (sequential scan through a single compare/age unit in the datapath).
//  - Packet: scans every slot unless dropped, then learns. Lookup: hit stops
//    early, miss scans all ENTRIES slots, then the results follow. Tick: one
//    slot aged per cycle; each result is held back until the next is known.
//  - Dropped packets, reply packets, quiet ticks and opcode 3 give a single
//    kind-0 result.
//  - CSR writes (csr_valid/csr_ready) are accepted every cycle; write only
//    while idle. Unknown indexes are ignored.
//  - Reset (synchronous) clears the slot table and loads CSR defaults.
// ----------------------------------------------------------------------------
module arp_cache_engine_top import arp_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_peer_ip,
   input  logic [47:0] req_sender_mac,
   input  logic [31:0] req_target_ip,
   input  logic [15:0] req_hw_type,
   input  logic [15:0] req_proto_type,
   input  logic [15:0] req_arp_opcode,
   input  logic        req_too_short,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [47:0] rsp_dest_mac,
   output logic [31:0] rsp_result_ip,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   logic [31:0] my_ip_ff;
   logic [7:0]  elife_ff, rlife_ff, rwin_ff, thr_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic [47:0] ans_mac, peer_mac;
   logic [31:0] peer_ip, scan_ip;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         my_ip_ff <= '0; elife_ff <= 8'd255; rlife_ff <= 8'd10;
         rwin_ff <= 8'd10; thr_ff <= 8'd220;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MY_IP:        my_ip_ff <= csr_wdata;
            CSR_ENTRY_LIFE:   elife_ff <= csr_wdata[7:0];
            CSR_REQUEST_LIFE: rlife_ff <= csr_wdata[7:0];
            CSR_REFRESH_WIN:  rwin_ff  <= csr_wdata[7:0];
            CSR_IN_USE_THR:   thr_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   arp_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_opcode, .req_peer_ip, .req_sender_mac, .req_target_ip,
      .req_hw_type, .req_proto_type, .req_arp_opcode, .req_too_short,
      .my_ip(my_ip_ff), .entry_lifetime(elife_ff), .request_lifetime(rlife_ff),
      .refresh_window(rwin_ff), .in_use_threshold(thr_ff),
      .ans_mac, .peer_ip, .peer_mac, .scan_ip
   );

   arp_ctrl u_ctrl (
      .clock, .reset, .start, .opcode(req_opcode), .busy, .cmd, .sts,
      .ans_mac, .peer_ip, .peer_mac, .scan_ip,
      .rsp_valid, .rsp_kind, .rsp_dest_mac, .rsp_result_ip, .rsp_last
   );

   // busy drops in the cycle the final result is on the ports
   a_last_before_idle: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last)
      else $error("busy dropped without final result");
   // no result while idle in this cycle and the cycle before
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> !rsp_valid)
      else $error("result without request");
   // last result ends the request
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("still busy after last result");
endmodule

[test/arp_cache_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// ARP cache engine testbench
// Drives packets, lookups and ticks through the command port, predicts every
// result with a behavioral cache model and checks each strobe in order.
// ----------------------------------------------------------------------------
module arp_cache_engine_top_tb import arp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] peer;
      logic [47:0] mac;
      logic [31:0] tip;
      logic [15:0] htype;
      logic [15:0] ptype;
      logic [15:0] aop;
      logic        short_f;
   } arp_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] dmac;
      logic [31:0] ip;
      logic        last;
   } arp_rsp_type;

   // directed row: request plus optional typed-in first result
   typedef struct packed {
      arp_req_type req;
      logic        has_exp;
      arp_rsp_type exp;
   } dir_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_peer_ip = '0;
   logic [47:0] req_sender_mac = '0;
   logic [31:0] req_target_ip = '0;
   logic [15:0] req_hw_type = '0;
   logic [15:0] req_proto_type = '0;
   logic [15:0] req_arp_opcode = '0;
   logic        req_too_short = 0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [47:0] rsp_dest_mac;
   logic [31:0] rsp_result_ip;
   logic        rsp_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   arp_cache_engine_top #(.ENTRIES(NSLOT)) i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor copy of the cache
   logic [31:0] m_my_ip;
   logic [7:0]  m_entry_life, m_req_life, m_refresh_win, m_use_thr;
   logic [31:0] s_ip [NSLOT];
   logic [47:0] s_mac [NSLOT];
   logic        s_done [NSLOT];
   logic [7:0]  s_exp [NSLOT];
   logic [7:0]  s_use [NSLOT];

   arp_rsp_type expected_rsp[$];
   int  errors = 0;
   int  idle_cycles = 0;
   logic [31:0] known_ips[$];

   function automatic int free_slot();
      int   pick;
      logic [7:0] lo;
      pick = 0;
      lo = LIFE_MAX;
      for (int i = 0; i < NSLOT; i++) begin
         if (s_exp[i] == 0) return i;
         if (s_exp[i] < lo) begin
            lo = s_exp[i];
            pick = i;
         end
      end
      return pick;
   endfunction

   task automatic push_rsp(ref int n, input logic [1:0] k, input logic [47:0] m,
                           input logic [31:0] ip);
      arp_rsp_type r;
      if (n >= MAX_RESULTS) return;
      r.kind = k; r.dmac = m; r.ip = ip; r.last = 0;
      expected_rsp.push_back(r);
      n++;
   endtask

   // work out the results of one request and update the cache copy
   task automatic predict_cache(input arp_req_type q);
      int n, s;
      logic found;
      logic [47:0] ans;
      arp_rsp_type r;
      n = 0;
      case (q.op)
         OP_PACKET: begin
            if (!q.short_f && q.htype == HTYPE_ETH && q.ptype == PTYPE_IPV4 &&
                q.tip == m_my_ip) begin
               s = -1;
               for (int i = 0; i < NSLOT; i++)
                  if (s < 0 && s_ip[i] == q.peer) s = i;
               if (s < 0) begin
                  s = free_slot();
                  s_ip[s] = q.peer;
               end
               s_done[s] = 1;
               s_mac[s] = q.mac;
               s_exp[s] = m_entry_life;
               if (q.aop == AOP_REQUEST) push_rsp(n, KIND_REPLY, q.mac, q.peer);
            end
         end
         OP_LOOKUP: begin
            found = 0;
            ans = BROADCAST_MAC;
            for (int i = 0; i < NSLOT; i++) begin
               if (!found && s_ip[i] == q.peer && s_exp[i] > 0) begin
                  if (s_done[i]) begin
                     s_use[i] = USE_FULL;
                     ans = s_mac[i];
                  end
                  found = 1;
               end
            end
            if (!found) begin
               s = free_slot();
               s_done[s] = 0;
               s_exp[s] = m_req_life;
               s_ip[s] = q.peer;
               push_rsp(n, KIND_REQUEST, BROADCAST_MAC, q.peer);
            end
            push_rsp(n, KIND_ANSWER, ans, q.peer);
         end
         OP_TICK: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (s_exp[i] > 0) s_exp[i]--;
               if (s_use[i] > 0) s_use[i]--;
               if (!s_done[i] && s_exp[i] > 0)
                  push_rsp(n, KIND_REQUEST, BROADCAST_MAC, s_ip[i]);
               if (s_done[i] && s_exp[i] < m_refresh_win && s_use[i] > m_use_thr)
                  push_rsp(n, KIND_REQUEST, BROADCAST_MAC, s_ip[i]);
            end
         end
         default: ;
      endcase
      if (n == 0) push_rsp(n, KIND_NONE, '0, '0);
      r = expected_rsp.pop_back();
      r.last = 1;
      expected_rsp.push_back(r);
   endtask

   // result checker; the receiver cannot stall so every strobe is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result kind=%0d mac=%h ip=%h", $time,
                     rsp_kind, rsp_dest_mac, rsp_result_ip);
            errors++;
         end else begin
            arp_rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_kind !== e.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp_kind);
               errors++;
            end
            if (rsp_dest_mac !== e.dmac) begin
               $display("%0t: dest_mac expected %h actual %h", $time, e.dmac,
                        rsp_dest_mac);
               errors++;
            end
            if (rsp_result_ip !== e.ip) begin
               $display("%0t: result_ip expected %h actual %h", $time, e.ip,
                        rsp_result_ip);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last expected %0d actual %0d", $time, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles in which no request, result or write is taken
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_cycles(input int n);
      repeat (n) @(posedge clock);
   endtask

   // one write; the channel idles before the next write is driven
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_MY_IP:        m_my_ip = val;
         CSR_ENTRY_LIFE:   m_entry_life = val[7:0];
         CSR_REQUEST_LIFE: m_req_life = val[7:0];
         CSR_REFRESH_WIN:  m_refresh_win = val[7:0];
         CSR_IN_USE_THR:   m_use_thr = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drain, then allow a full scan for any in-flight work
   task automatic settle();
      while (expected_rsp.size() != 0) @(posedge clock);
      wait_cycles(2 * NSLOT + 8);
   endtask

   // send one request; start stays high only for the accepting edge
   task automatic send_request(input arp_req_type q, input logic random_gap);
      if (random_gap) wait_cycles($urandom_range(0, 11));
      start          <= 1;
      req_opcode     <= q.op;
      req_peer_ip    <= q.peer;
      req_sender_mac <= q.mac;
      req_target_ip  <= q.tip;
      req_hw_type    <= q.htype;
      req_proto_type <= q.ptype;
      req_arp_opcode <= q.aop;
      req_too_short  <= q.short_f;
      do @(posedge clock); while (busy);
      predict_cache(q);
      start <= 0;
      if (q.op == OP_LOOKUP || q.op == OP_PACKET) known_ips.push_back(q.peer);
      // busy is still high at this edge, so the wait costs nothing
      @(posedge clock);
   endtask

   function automatic arp_req_type good_packet(input logic [31:0] peer,
                                               input logic [47:0] mac,
                                               input logic [15:0] aop);
      arp_req_type q;
      q = '0;
      q.op = OP_PACKET; q.peer = peer; q.mac = mac; q.tip = m_my_ip;
      q.htype = HTYPE_ETH; q.ptype = PTYPE_IPV4; q.aop = aop;
      return q;
   endfunction

   function automatic arp_req_type make_op(input logic [1:0] op, input logic [31:0] peer);
      arp_req_type q;
      q = '0;
      q.op = op;
      q.peer = peer;
      return q;
   endfunction

   function automatic logic [31:0] pick_ip();
      if (known_ips.size() != 0 && $urandom_range(0, 3) != 0)
         return known_ips[$urandom_range(0, known_ips.size() - 1)];
      return {28'h0A00_000, 4'($urandom_range(0, 15))} ^
             ($urandom_range(0, 7) == 0 ? $urandom : 32'h0);
   endfunction

   function automatic arp_req_type random_request();
      arp_req_type q;
      int sel;
      sel = $urandom_range(0, 99);
      q = good_packet(pick_ip(), 48'({$urandom, $urandom}),
                      16'($urandom_range(1, 2)));
      if (sel < 35) begin
         // well-formed packet
      end else if (sel < 45) begin
         // broken packet: one header check fails
         case ($urandom_range(0, 3))
            0: q.short_f = 1;
            1: q.htype = 16'($urandom);
            2: q.ptype = 16'($urandom);
            default: q.tip = $urandom;
         endcase
         if ($urandom_range(0, 3) == 0) q.aop = 16'($urandom);
      end else if (sel < 75) begin
         q = make_op(OP_LOOKUP, pick_ip());
      end else if (sel < 97) begin
         q = make_op(OP_TICK, $urandom);
      end else begin
         q = make_op(OP_UNUSED, $urandom);
      end
      if ($urandom_range(0, 4) == 0) begin
         // noise: a new random MAC, and random values on fields a non-packet operation does not look at
         q.mac = 48'({$urandom, $urandom});
         if (q.op != OP_PACKET) begin
            q.tip = $urandom; q.htype = 16'($urandom); q.ptype = 16'($urandom);
            q.aop = 16'($urandom); q.short_f = 1'($urandom);
         end
      end
      return q;
   endfunction

   task automatic run_directed();
      dir_row_type rows[$];
      dir_row_type d;
      arp_rsp_type got;
      logic [31:0] peer_a;
      peer_a = 32'hC0A8_0001;
      // tick on an empty table is quiet
      d = '0; d.req = make_op(OP_TICK, '0); d.has_exp = 1;
      d.exp = '{KIND_NONE, '0, '0, 1'b1}; rows.push_back(d);
      // opcode 3 does nothing
      d = '0; d.req = make_op(OP_UNUSED, '1); d.req.mac = '1; d.req.tip = '1;
      d.req.htype = '1; d.req.ptype = '1; d.req.aop = '1; d.req.short_f = 1;
      d.has_exp = 1; d.exp = '{KIND_NONE, '0, '0, 1'b1}; rows.push_back(d);
      // lookup miss: request, then broadcast answer
      d = '0; d.req = make_op(OP_LOOKUP, peer_a); d.has_exp = 1;
      d.exp = '{KIND_REQUEST, BROADCAST_MAC, peer_a, 1'b0}; rows.push_back(d);
      // lookup of pending entry: broadcast answer only
      d = '0; d.req = make_op(OP_LOOKUP, peer_a); d.has_exp = 1;
      d.exp = '{KIND_ANSWER, BROADCAST_MAC, peer_a, 1'b1}; rows.push_back(d);
      // tick retries the pending request
      d = '0; d.req = make_op(OP_TICK, '0); rows.push_back(d);
      // dropped packets: short, bad htype, bad ptype, wrong target
      d = '0; d.req = good_packet(peer_a, 48'h0200_0000_0001, AOP_REQUEST);
      d.req.short_f = 1; d.has_exp = 1; d.exp = '{KIND_NONE, '0, '0, 1'b1};
      rows.push_back(d);
      d.req.short_f = 0; d.req.htype = 16'hFFFF; rows.push_back(d);
      d.req.htype = HTYPE_ETH; d.req.ptype = 16'hFFFF; rows.push_back(d);
      d.req.ptype = PTYPE_IPV4; d.req.tip = ~m_my_ip; rows.push_back(d);
      // ARP request packet gives a reply to the sender
      d = '0; d.req = good_packet(peer_a, 48'hFFFF_FFFF_FFFE, AOP_REQUEST);
      d.has_exp = 1; d.exp = '{KIND_REPLY, 48'hFFFF_FFFF_FFFE, peer_a, 1'b1};
      rows.push_back(d);
      // ARP reply packet is learned quietly
      d = '0; d.req = good_packet(32'hFFFF_FFFF, 48'h0, 16'd2); d.has_exp = 1;
      d.exp = '{KIND_NONE, '0, '0, 1'b1}; rows.push_back(d);
      // lookup hit returns the cached MAC
      d = '0; d.req = make_op(OP_LOOKUP, peer_a); d.has_exp = 1;
      d.exp = '{KIND_ANSWER, 48'hFFFF_FFFF_FFFE, peer_a, 1'b1}; rows.push_back(d);
      d = '0; d.req = make_op(OP_LOOKUP, 32'hFFFF_FFFF); rows.push_back(d);
      d = '0; d.req = make_op(OP_LOOKUP, 32'h0); rows.push_back(d);
      for (int i = 0; i < rows.size(); i++) begin
         // drain so the head of the queue belongs to this row
         while (expected_rsp.size() != 0) @(posedge clock);
         send_request(rows[i].req, 1'b0);
         if (rows[i].has_exp) begin
            got = expected_rsp[0];
            if (got !== rows[i].exp) begin
               $display("%0t: directed row %0d expected %h actual %h", $time, i,
                        rows[i].exp, got);
               errors++;
            end
         end
      end
   endtask

   initial begin
      m_my_ip = 0; m_entry_life = LIFE_MAX; m_req_life = 8'd10;
      m_refresh_win = 8'd10; m_use_thr = 8'd220;
      for (int i = 0; i < NSLOT; i++) begin
         s_ip[i] = 0; s_mac[i] = 0; s_done[i] = 0; s_exp[i] = 0; s_use[i] = 0;
      end
      wait_cycles(10);
      reset <= 0;
      @(posedge clock);

      // defaults first, my_ip 0 as after reset
      run_directed();
      settle();

      // phase settings: extremes and short lifetimes that make aging visible
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_MY_IP, 32'hFFFF_FFFF);
               write_csr(CSR_ENTRY_LIFE, 32'd1);
               write_csr(CSR_REQUEST_LIFE, 32'd255);
               write_csr(CSR_REFRESH_WIN, 32'd0);
               write_csr(CSR_IN_USE_THR, 32'd0);
            end
            1: begin
               write_csr(CSR_MY_IP, 32'h0A00_0001);
               write_csr(CSR_ENTRY_LIFE, 32'd6);
               write_csr(CSR_REQUEST_LIFE, 32'd3);
               write_csr(CSR_REFRESH_WIN, 32'd255);
               write_csr(CSR_IN_USE_THR, 32'd250);
            end
            2: begin
               write_csr(CSR_MY_IP, $urandom);
               write_csr(CSR_ENTRY_LIFE, 32'd255);
               write_csr(CSR_REQUEST_LIFE, 32'd1);
               write_csr(CSR_REFRESH_WIN, 32'd254);
               write_csr(CSR_IN_USE_THR, 32'd255);
               // unknown index must be ignored
               write_csr(CSR_UNUSED, $urandom);
            end
            default: begin
               write_csr(CSR_ENTRY_LIFE, $urandom_range(4, 20));
               write_csr(CSR_REQUEST_LIFE, $urandom_range(2, 8));
               write_csr(CSR_REFRESH_WIN, $urandom_range(5, 30));
               write_csr(CSR_IN_USE_THR, $urandom_range(200, 254));
            end
         endcase
         for (int k = 0; k < 50; k++) begin
            // bursts with no gap, and otherwise random gaps
            send_request(random_request(), (k % 16) > 5);
            if (k == 25) settle();
         end
         settle();
      end

      settle();
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
